[hdl/lsts_pkg.sv]
`default_nettype none

package lsts_pkg;

    localparam int STORE_DEPTH     = 16;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int IDX_W           = 4;
    localparam int COUNT_W         = 5;
    localparam int FTYPE_W         = 3;
    localparam int DELAY_W         = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [FTYPE_W-1:0] FTYPE_MAX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DELAY = 1'd1;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_START  = 3'd1,
        MODE_STOP   = 3'd2,
        MODE_PAUSE  = 3'd3,
        MODE_RESUME = 3'd4,
        MODE_APPEND = 3'd5,
        MODE_SET    = 3'd6,
        MODE_CLEAR  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        EV_OK    = 3'd0,
        EV_REJ   = 3'd1,
        EV_EXEC  = 3'd2,
        EV_DONE  = 3'd3,
        EV_TABLE = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        RUN_IDLE   = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_PAUSED = 2'd2
    } t_run;

    typedef struct packed {
        logic [FTYPE_W-1:0] ftype;
        logic [DELAY_W-1:0] delay;
    } t_entry;

    typedef struct packed {
        t_event             ev;
        logic [IDX_W-1:0]   idx;
        logic [FTYPE_W-1:0] ftype;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
        t_run    state;
    } t_group;

endpackage

`default_nettype wire

[hdl/lsts_front.sv]
`default_nettype none

module lsts_front
    import lsts_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_mode,
    input  wire logic [IDX_W-1:0]   i_entry_index,
    input  wire logic [FTYPE_W-1:0] i_frame_type,
    input  wire logic [DELAY_W-1:0] i_delay_ticks,
    input  wire logic               i_cyclic,
    input  wire logic [DELAY_W-1:0] i_default_delay,
    input  wire logic               i_q_ready,
    output logic                    o_push,
    output t_group                  o_group
);

    localparam int CAP_INT = (MAX_ENTRIES < STORE_DEPTH) ? MAX_ENTRIES : STORE_DEPTH;
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);

    t_entry               r_table [STORE_DEPTH];
    t_entry               r_cache;
    t_entry               n_cache;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     n_cur;
    t_run                 r_state;
    t_run                 n_state;
    logic [DELAY_W-1:0]   r_el;
    logic [DELAY_W-1:0]   n_el;

    logic                 accept;
    logic                 wr_en;
    logic [IDX_W-1:0]     rd_addr;
    t_entry               rd_data;
    logic                 cur_valid;
    logic [COUNT_W-1:0]   nxt;
    logic                 at_end;
    logic [DELAY_W-1:0]   el_inc;
    logic [DELAY_W-1:0]   need;

    assign accept     = i_in_valid && i_q_ready;
    assign o_in_ready = i_q_ready;
    assign cur_valid  = {1'b0, r_cur} < r_count;
    assign nxt        = {1'b0, r_cur} + COUNT_W'(1);
    assign at_end     = nxt >= r_count;
    assign el_inc     = (r_el != '1) ? r_el + DELAY_W'(1) : r_el;
    assign need       = cur_valid ? r_cache.delay : i_default_delay;
    assign rd_addr    = (t_mode'(i_mode) == MODE_SET) ? i_entry_index :
                        (at_end ? '0 : nxt[IDX_W-1:0]);
    assign rd_data    = r_table[rd_addr];

    always_comb begin
        logic    a_v;
        logic    b_v;
        logic    is_cmd;
        t_result a_res;
        t_result b_res;
        t_event  ans;

        a_v     = 1'b0;
        b_v     = 1'b0;
        is_cmd  = 1'b1;
        ans     = EV_OK;
        a_res   = '{ev: EV_DONE, idx: r_cur, ftype: r_cache.ftype};
        b_res   = '{ev: EV_OK, idx: r_cur, ftype: '0};
        n_cache = r_cache;
        n_count = r_count;
        n_cur   = r_cur;
        n_state = r_state;
        n_el    = r_el;
        wr_en   = 1'b0;

        case (t_mode'(i_mode))
            MODE_TICK: begin
                is_cmd = 1'b0;
                if (r_state == RUN_ACTIVE) begin
                    if (el_inc < need) begin
                        n_el = el_inc;
                    end else begin
                        n_el = '0;
                        a_v  = cur_valid;
                        if (at_end && !i_cyclic) begin
                            n_state = RUN_IDLE;
                            b_v     = 1'b1;
                            b_res   = '{ev: EV_TABLE, idx: r_cur,
                                        ftype: cur_valid ? r_cache.ftype : '0};
                        end else begin
                            n_cur   = at_end ? '0 : nxt[IDX_W-1:0];
                            n_cache = rd_data;
                            b_v     = {1'b0, n_cur} < r_count;
                            b_res   = '{ev: EV_EXEC, idx: n_cur, ftype: rd_data.ftype};
                        end
                    end
                end
            end
            MODE_START: begin
                if (r_state != RUN_ACTIVE) begin
                    n_state = RUN_ACTIVE;
                    n_el    = '0;
                    a_v     = cur_valid;
                    a_res   = '{ev: EV_EXEC, idx: r_cur, ftype: r_cache.ftype};
                end
            end
            MODE_STOP: begin
                if (r_state == RUN_ACTIVE) begin
                    n_state = RUN_IDLE;
                end else begin
                    ans = EV_REJ;
                end
            end
            MODE_PAUSE: begin
                if (r_state == RUN_ACTIVE) begin
                    n_state = RUN_PAUSED;
                end else begin
                    ans = EV_REJ;
                end
            end
            MODE_RESUME: begin
                if (r_state == RUN_PAUSED) begin
                    n_state = RUN_ACTIVE;
                    n_el    = '0;
                end else begin
                    ans = EV_REJ;
                end
            end
            MODE_APPEND: begin
                if (r_count >= CAP || i_frame_type > FTYPE_MAX) begin
                    ans = EV_REJ;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + COUNT_W'(1);
                    if (r_count == {1'b0, r_cur}) begin
                        n_cache = '{ftype: i_frame_type, delay: i_delay_ticks};
                    end
                end
            end
            MODE_SET: begin
                if ({1'b0, i_entry_index} >= r_count || r_state == RUN_ACTIVE) begin
                    ans = EV_REJ;
                end else begin
                    n_cur   = i_entry_index;
                    n_cache = rd_data;
                end
            end
            MODE_CLEAR: begin
                if (r_state == RUN_ACTIVE) begin
                    ans = EV_REJ;
                end else begin
                    n_count = '0;
                    n_cur   = '0;
                    n_el    = '0;
                end
            end
            default: begin
                is_cmd = 1'b0;
            end
        endcase

        if (is_cmd) begin
            b_v   = 1'b1;
            b_res = '{ev: ans, idx: n_cur,
                      ftype: ({1'b0, n_cur} < n_count) ? n_cache.ftype : '0};
        end

        o_group.two   = a_v && b_v;
        o_group.r0    = a_v ? a_res : b_res;
        o_group.r1    = b_res;
        o_group.state = n_state;
        o_push        = accept && (a_v || b_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cur   <= '0;
            r_state <= RUN_IDLE;
            r_el    <= '0;
        end else if (accept) begin
            r_count <= n_count;
            r_cur   <= n_cur;
            r_state <= n_state;
            r_el    <= n_el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cache <= n_cache;
            if (wr_en) begin
                r_table[r_count[IDX_W-1:0]] <= '{ftype: i_frame_type, delay: i_delay_ticks};
            end
        end
    end

endmodule

`default_nettype wire

[hdl/lsts_queue.sv]
`default_nettype none

module lsts_queue
    import lsts_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_data,
    output logic        o_ready,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_group      o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_group           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_cnt != (PTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hdl/lsts_back.sv]
`default_nettype none

module lsts_back
    import lsts_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire t_group        i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [2:0]         o_event_res,
    output logic [IDX_W-1:0]   o_slot_index,
    output logic [FTYPE_W-1:0] o_slot_type,
    output logic [1:0]         o_run_state,
    output logic               o_last
);

    logic    r_busy;
    logic    r_phase;
    t_group  r_grp;
    t_result cur;
    logic    is_last;
    logic    take;

    assign cur     = r_phase ? r_grp.r1 : r_grp.r0;
    assign is_last = !r_grp.two || r_phase;
    assign take    = r_busy && i_out_ready;
    assign o_pop   = i_q_valid && (!r_busy || (take && is_last));

    assign o_out_valid  = r_busy;
    assign o_event_res  = cur.ev;
    assign o_slot_index = cur.idx;
    assign o_slot_type  = cur.ftype;
    assign o_run_state  = r_grp.state;
    assign o_last       = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (o_pop) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
        end else if (take) begin
            if (is_last) begin
                r_busy  <= 1'b0;
                r_phase <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_q_data;
        end
    end

endmodule

`default_nettype wire

[hdl/lin_schedule_table_sequencer.sv]
// The first result of an item is written to the queue, then to the output stage's group register,
// before it can be taken. Throughput: one item per cycle while the queue has room. An item with two
// results holds the output until both are taken, a two-entry queue between the command decoder and
// the output stage absorbs it, and the input stalls only while that queue is full.
// Reset is synchronous and active low; it clears run state, index, entry count, elapsed
// count and configuration. Table entries are undefined until appended.
`default_nettype none

module lin_schedule_table_sequencer
    import lsts_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [2:0]            i_mode,
    input  wire logic [IDX_W-1:0]      i_entry_index,
    input  wire logic [FTYPE_W-1:0]    i_frame_type,
    input  wire logic [DELAY_W-1:0]    i_delay_ticks,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [2:0]                 o_event_res,
    output logic [IDX_W-1:0]           o_slot_index,
    output logic [FTYPE_W-1:0]         o_slot_type,
    output logic [1:0]                 o_run_state,
    output logic                       o_last,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_cyclic;
    logic [DELAY_W-1:0] r_default_delay;
    logic               q_ready;
    logic               q_valid;
    logic               push;
    logic               pop;
    t_group             push_data;
    t_group             pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyclic        <= 1'b0;
            r_default_delay <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CYCLIC: begin
                    r_cyclic <= i_cfg_data[0];
                end
                CFG_DEFAULT_DELAY: begin
                    r_default_delay <= i_cfg_data[DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    lsts_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_entry_index   (i_entry_index),
        .i_frame_type    (i_frame_type),
        .i_delay_ticks   (i_delay_ticks),
        .i_cyclic        (r_cyclic),
        .i_default_delay (r_default_delay),
        .i_q_ready       (q_ready),
        .o_push          (push),
        .o_group         (push_data)
    );

    lsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (pop_data)
    );

    lsts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (pop_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_slot_index (o_slot_index),
        .o_slot_type  (o_slot_type),
        .o_run_state  (o_run_state),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

[tb/tb_lin_schedule_table_sequencer.sv]
`timescale 1ns / 100ps

module tb_lin_schedule_table_sequencer;
    import lsts_pkg::*;

    localparam int TABLE_CAP    = (MAX_ENTRIES_DEF < STORE_DEPTH) ? MAX_ENTRIES_DEF : STORE_DEPTH;
    localparam int DRAIN_WAIT   = 8;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_WORDS = 1400;
    localparam int PHASES       = 6;

    typedef struct {
        t_event             ev;
        logic [IDX_W-1:0]   idx;
        logic [FTYPE_W-1:0] ftype;
        t_run               state;
        logic               last;
    } t_sched_event;

    class sched_scoreboard;
        t_entry             slots [STORE_DEPTH];
        logic [COUNT_W-1:0] n_entries;
        logic [IDX_W-1:0]   cur_slot;
        t_run               run;
        logic [DELAY_W-1:0] elapsed;
        logic               wrap;
        logic [DELAY_W-1:0] fallback_delay;
        t_sched_event       due_events[$];
        t_sched_event       fresh[$];
        int                 faults;
        int                 matched;

        function new();
            foreach (slots[i]) slots[i] = '0;
            n_entries      = '0;
            cur_slot       = '0;
            run            = RUN_IDLE;
            elapsed        = '0;
            wrap           = 1'b0;
            fallback_delay = '0;
            faults         = 0;
            matched        = 0;
        endfunction

        function bit holds(logic [IDX_W-1:0] i);
            return {1'b0, i} < n_entries;
        endfunction

        function void emit(t_event ev, logic [IDX_W-1:0] i);
            t_sched_event e;
            e.ev    = ev;
            e.idx   = i;
            e.ftype = holds(i) ? slots[i].ftype : '0;
            e.state = RUN_IDLE;
            e.last  = 1'b0;
            fresh.push_back(e);
        endfunction

        function void reply(bit ok);
            if (ok) begin
                emit(EV_OK, cur_slot);
            end else begin
                emit(EV_REJ, cur_slot);
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] r, logic [CFG_DATA_W-1:0] d);
            if (r == CFG_CYCLIC) begin
                wrap = d[0];
            end else begin
                fallback_delay = d[DELAY_W-1:0];
            end
        endfunction

        function void count_tick();
            logic [DELAY_W-1:0] need;
            logic [COUNT_W-1:0] nxt;
            if (run != RUN_ACTIVE) return;
            if (elapsed != '1) elapsed++;
            need = holds(cur_slot) ? slots[cur_slot].delay : fallback_delay;
            if (elapsed < need) return;
            if (holds(cur_slot)) emit(EV_DONE, cur_slot);
            elapsed = '0;
            nxt = {1'b0, cur_slot} + 1'b1;
            if (nxt >= n_entries) begin
                if (!wrap) begin
                    run = RUN_IDLE;
                    emit(EV_TABLE, cur_slot);
                    return;
                end
                nxt = '0;
            end
            cur_slot = nxt[IDX_W-1:0];
            if (holds(cur_slot)) emit(EV_EXEC, cur_slot);
        endfunction

        function void note_word(t_mode m, logic [IDX_W-1:0] ei, logic [FTYPE_W-1:0] ft,
                                logic [DELAY_W-1:0] dl);
            bit ok;
            fresh.delete();
            case (m)
                MODE_TICK: begin
                    count_tick();
                end
                MODE_START: begin
                    if (run != RUN_ACTIVE) begin
                        run     = RUN_ACTIVE;
                        elapsed = '0;
                        if (holds(cur_slot)) emit(EV_EXEC, cur_slot);
                    end
                    reply(1'b1);
                end
                MODE_STOP: begin
                    ok = (run == RUN_ACTIVE);
                    if (ok) run = RUN_IDLE;
                    reply(ok);
                end
                MODE_PAUSE: begin
                    ok = (run == RUN_ACTIVE);
                    if (ok) run = RUN_PAUSED;
                    reply(ok);
                end
                MODE_RESUME: begin
                    ok = (run == RUN_PAUSED);
                    if (ok) begin
                        run     = RUN_ACTIVE;
                        elapsed = '0;
                    end
                    reply(ok);
                end
                MODE_APPEND: begin
                    ok = (n_entries < TABLE_CAP) && (ft <= FTYPE_MAX);
                    if (ok) begin
                        slots[n_entries[IDX_W-1:0]] = {ft, dl};
                        n_entries++;
                    end
                    reply(ok);
                end
                MODE_SET: begin
                    ok = ({1'b0, ei} < n_entries) && (run != RUN_ACTIVE);
                    if (ok) cur_slot = ei;
                    reply(ok);
                end
                default: begin
                    ok = (run != RUN_ACTIVE);
                    if (ok) begin
                        n_entries = '0;
                        cur_slot  = '0;
                        elapsed   = '0;
                    end
                    reply(ok);
                end
            endcase
            foreach (fresh[k]) begin
                fresh[k].state = run;
                fresh[k].last  = (k == fresh.size() - 1);
                due_events.push_back(fresh[k]);
            end
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_word(logic [2:0] ev, logic [IDX_W-1:0] i, logic [FTYPE_W-1:0] ft,
                                 logic [1:0] st, logic lst);
            t_sched_event e;
            if (due_events.size() == 0) begin
                flag($sformatf("unexpected word ev %0d slot %0d type %0d state %0d last %0b",
                               ev, i, ft, st, lst));
                return;
            end
            e = due_events.pop_front();
            if (ev !== e.ev || i !== e.idx || ft !== e.ftype || st !== e.state
                    || lst !== e.last) begin
                flag($sformatf({"expected ev %0d slot %0d type %0d state %0d last %0b, ",
                                "got ev %0d slot %0d type %0d state %0d last %0b"},
                               e.ev, e.idx, e.ftype, e.state, e.last, ev, i, ft, st, lst));
            end else begin
                matched++;
            end
        endfunction

        function int pending();
            return due_events.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [2:0]            i_mode;
    logic [IDX_W-1:0]      i_entry_index;
    logic [FTYPE_W-1:0]    i_frame_type;
    logic [DELAY_W-1:0]    i_delay_ticks;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [2:0]            o_event_res;
    logic [IDX_W-1:0]      o_slot_index;
    logic [FTYPE_W-1:0]    o_slot_type;
    logic [1:0]            o_run_state;
    logic                  o_last;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sched_scoreboard sb = new();
    bit              sender_gaps     = 1'b1;
    bit              receiver_stalls = 1'b1;
    int              words_sent      = 0;
    int              config_loads    = 0;
    int              cycles          = 0;

    lin_schedule_table_sequencer u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_lin_schedule_table_sequencer: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word(o_event_res, o_slot_index, o_slot_type, o_run_state, o_last);
        end
    end

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = receiver_stalls ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_word(t_mode m, logic [IDX_W-1:0] ei, logic [FTYPE_W-1:0] ft,
                             logic [DELAY_W-1:0] dl);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= m;
        i_entry_index <= ei;
        i_frame_type  <= ft;
        i_delay_ticks <= dl;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(m, ei, ft, dl);
        words_sent++;
    endtask

    task automatic cmd(t_mode m);
        send_word(m, IDX_W'($urandom), FTYPE_W'($urandom), DELAY_W'($urandom));
    endtask

    task automatic append_random();
        logic [FTYPE_W-1:0] ft;
        logic [DELAY_W-1:0] dl;
        ft = FTYPE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
        dl = DELAY_W'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 5));
        send_word(MODE_APPEND, IDX_W'($urandom), ft, dl);
    endtask

    // The block may still be busy with an item that gives no word, so wait out its latency.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_config(logic cyc, logic [DELAY_W-1:0] dflt);
        logic [CFG_DATA_W-2:0] junk;
        junk = (CFG_DATA_W - 1)'($urandom);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_CYCLIC;
        i_cfg_data  <= {junk, cyc};
        @(posedge i_clk);
        sb.set_register(CFG_CYCLIC, {junk, cyc});
        i_cfg_index <= CFG_DEFAULT_DELAY;
        i_cfg_data  <= dflt;
        @(posedge i_clk);
        sb.set_register(CFG_DEFAULT_DELAY, dflt);
        i_cfg_wr_en <= 1'b0;
        config_loads++;
    endtask

    task automatic random_burst();
        int kind;
        int n;
        sender_gaps     = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            cmd(MODE_STOP);
            cmd(MODE_CLEAR);
            n = $urandom_range(1, 18);
            repeat (n) append_random();
        end else if (kind < 7) begin
            if ($urandom_range(0, 1) == 1) begin
                send_word(MODE_SET, IDX_W'($urandom), FTYPE_W'($urandom), DELAY_W'($urandom));
            end
            cmd(MODE_START);
            n = $urandom_range(1, 24);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) begin
                    cmd(t_mode'($urandom_range(1, 5)));
                end else begin
                    cmd(MODE_TICK);
                end
            end
        end else if (kind == 7) begin
            cmd(MODE_PAUSE);
            n = $urandom_range(0, 3);
            repeat (n) cmd(MODE_TICK);
            cmd(MODE_RESUME);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) cmd(t_mode'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        int base;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_mode        <= MODE_TICK;
        i_entry_index <= '0;
        i_frame_type  <= '0;
        i_delay_ticks <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_CYCLIC;
        i_cfg_data    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_config(1'b0, 16'd0);

        cmd(MODE_TICK);
        cmd(MODE_STOP);
        cmd(MODE_PAUSE);
        cmd(MODE_RESUME);
        send_word(MODE_SET, 4'd0, 3'd0, 16'd0);
        send_word(MODE_APPEND, 4'd0, 3'd5, 16'd3);
        send_word(MODE_APPEND, 4'hF, 3'd7, 16'hFFFF);
        cmd(MODE_START);
        cmd(MODE_TICK);
        cmd(MODE_CLEAR);
        send_word(MODE_APPEND, 4'd0, 3'd0, 16'd0);
        send_word(MODE_APPEND, 4'd0, FTYPE_MAX, 16'd2);
        send_word(MODE_APPEND, 4'd0, 3'd2, 16'd1);
        send_word(MODE_SET, 4'hF, 3'd0, 16'd0);
        send_word(MODE_SET, 4'd1, 3'd0, 16'd0);
        cmd(MODE_START);
        cmd(MODE_START);
        send_word(MODE_SET, 4'd0, 3'd0, 16'd0);
        cmd(MODE_CLEAR);
        cmd(MODE_PAUSE);
        cmd(MODE_TICK);
        cmd(MODE_START);
        cmd(MODE_PAUSE);
        cmd(MODE_RESUME);
        cmd(MODE_RESUME);
        repeat (3) cmd(MODE_TICK);
        cmd(MODE_START);
        cmd(MODE_STOP);

        settle();
        load_config(1'b0, 16'd40);
        sender_gaps = 1'b0;
        cmd(MODE_CLEAR);
        cmd(MODE_START);
        repeat (40) cmd(MODE_TICK);
        send_word(MODE_APPEND, 4'd0, FTYPE_MAX, 16'd30);
        cmd(MODE_START);
        repeat (30) cmd(MODE_TICK);

        base = words_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: load_config(1'b1, 16'd0);
                1: load_config(1'b0, 16'd2);
                2: load_config(1'b1, 16'hFFFF);
                3: load_config(1'b1, 16'd1);
                default: load_config(1'($urandom_range(0, 1)), DELAY_W'($urandom_range(0, 6)));
            endcase
            while (words_sent - base < (ph + 1) * RANDOM_WORDS / PHASES) random_burst();
        end

        settle();
        $display("run covered %0d words over %0d register loads, incl. two long-delay runs;",
                 words_sent, config_loads);
        $display("%0d result words matched, %0d mismatches", sb.matched, sb.faults);
        if (sb.faults == 0) begin
            $display("tb_lin_schedule_table_sequencer: clean");
        end else begin
            $display("tb_lin_schedule_table_sequencer: errors");
        end
        $finish;
    end

endmodule

[lin_schedule_table_sequencer.f]
hdl/lsts_pkg.sv
hdl/lsts_front.sv
hdl/lsts_queue.sv
hdl/lsts_back.sv
hdl/lin_schedule_table_sequencer.sv
tb/tb_lin_schedule_table_sequencer.sv
